### hdl/cmab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmab_pkg
// Shared types and constants of the disc-masked RGB565 overlay blend.
// ----------------------------------------------------------------------------
package cmab_pkg;

   localparam int COORD_RANGE = 1024;
   localparam int COORD_W     = 10;
   localparam int PIXEL_W     = 16;
   localparam int ALPHA_W     = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [COORD_W-1:0] COORD_LIMIT = COORD_W'(COORD_RANGE - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_ALPHA   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAY_COLOR = 3'd4;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [PIXEL_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_out;
      logic               was_blended;
   } rsp_type;

   typedef struct packed {
      logic s1_load;
      logic s2_load;
   } pipe_ctrl_type;

endpackage

### hdl/cmab_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmab_blend_unit
// Two-stage per-channel alpha blend: weighted sum, then rounded divide by 255.
// ----------------------------------------------------------------------------
module cmab_blend_unit (
   input  logic                          clock,
   input  cmab_pkg::pipe_ctrl_type       ctrl,
   input  logic [cmab_pkg::PIXEL_W-1:0]  dst_pixel,
   input  logic [cmab_pkg::PIXEL_W-1:0]  src_pixel,
   input  logic [cmab_pkg::ALPHA_W-1:0]  alpha,
   output logic [cmab_pkg::PIXEL_W-1:0]  blend_pixel
);

   function automatic logic [13:0] mix_sum(input logic [5:0] s, input logic [5:0] d,
                                           input logic [7:0] a);
      logic [7:0] inv;
      inv = 8'd255 - a;
      return 14'(s) * 14'(a) + 14'(d) * 14'(inv) + 14'd127;
   endfunction

   // floor(x / 255) for x below 16320
   function automatic logic [5:0] div255(input logic [13:0] x);
      logic [13:0] t;
      t = x + 14'd1 + 14'(x >> 8);
      return t[13:8];
   endfunction

   logic [13:0] red_sum_ff, red_sum_in;
   logic [13:0] grn_sum_ff, grn_sum_in;
   logic [13:0] blu_sum_ff, blu_sum_in;
   logic [15:0] blend_ff, blend_in;
   logic [5:0]  red_q, grn_q, blu_q;

   always_comb begin
      red_sum_in = mix_sum({1'b0, src_pixel[15:11]}, {1'b0, dst_pixel[15:11]}, alpha);
      grn_sum_in = mix_sum(src_pixel[10:5], dst_pixel[10:5], alpha);
      blu_sum_in = mix_sum({1'b0, src_pixel[4:0]}, {1'b0, dst_pixel[4:0]}, alpha);
   end

   always_comb begin
      red_q    = div255(red_sum_ff);
      grn_q    = div255(grn_sum_ff);
      blu_q    = div255(blu_sum_ff);
      blend_in = {red_q[4:0], grn_q, blu_q[4:0]};
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         red_sum_ff <= red_sum_in;
         grn_sum_ff <= grn_sum_in;
         blu_sum_ff <= blu_sum_in;
      end
      if (ctrl.s2_load) begin
         blend_ff <= blend_in;
      end
   end

   assign blend_pixel = blend_ff;

endmodule

### hdl/circle_masked_rgb565_alpha_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_masked_rgb565_alpha_blend
// Blends a configured RGB565 colour over pixels that lie inside a disc.
//
// req_valid/req_stall/req_data carry one pixel item (x, y, RGB565 colour).
// rsp_valid/rsp_stall/rsp_data return the resulting pixel and a blended flag,
// one item for every item taken, in order.
// csr_valid/csr_ready/csr_index/csr_wdata write the centre, radius, alpha and
// overlay colour; csr_ready is always high, writes to unused indexes are
// dropped. Write the registers only while no item is in flight.
// Each accepted item passes three register stages (distance and channel sums,
// squares and divide by 255, compare and select) before rsp_valid; throughput
// is one item per cycle while the receiver does not stall.
// Reset clears the registers to zero (overlay disabled) and empties the
// pipeline. A stalled receiver holds the output item; stages behind it keep
// filling bubbles and req_stall rises only once every stage holds an item.
// ----------------------------------------------------------------------------
module circle_masked_rgb565_alpha_blend #(
   parameter int COORD_RANGE = cmab_pkg::COORD_RANGE
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  cmab_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output cmab_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cmab_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cmab_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [cmab_pkg::COORD_W-1:0] COORD_LIMIT = 10'(COORD_RANGE - 1);

   function automatic logic [cmab_pkg::COORD_W-1:0] clamp_coord(
      input logic [cmab_pkg::COORD_W-1:0] v);
      if ({3'b000, v} >= 13'(COORD_RANGE)) begin
         return COORD_LIMIT;
      end
      return v;
   endfunction

   function automatic logic [9:0] abs_diff(input logic [9:0] a, input logic [9:0] b);
      logic [10:0] d;
      logic [10:0] n;
      d = {1'b0, a} - {1'b0, b};
      n = -d;
      return d[10] ? n[9:0] : d[9:0];
   endfunction

   // configuration registers
   logic [9:0]  center_x_ff, center_y_ff, radius_ff;
   logic [7:0]  blend_alpha_ff;
   logic [15:0] overlay_color_ff;
   logic        csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff      <= '0;
         center_y_ff      <= '0;
         radius_ff        <= '0;
         blend_alpha_ff   <= '0;
         overlay_color_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            cmab_pkg::CSR_CENTER_X:      center_x_ff      <= csr_wdata[9:0];
            cmab_pkg::CSR_CENTER_Y:      center_y_ff      <= csr_wdata[9:0];
            cmab_pkg::CSR_RADIUS:        radius_ff        <= csr_wdata[9:0];
            cmab_pkg::CSR_BLEND_ALPHA:   blend_alpha_ff   <= csr_wdata[7:0];
            cmab_pkg::CSR_OVERLAY_COLOR: overlay_color_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // pipeline control
   logic v1_ff, v2_ff, v3_ff;
   logic ready1, ready2, ready3;
   logic req_take;
   cmab_pkg::pipe_ctrl_type ctrl;

   assign ready3    = ~v3_ff | ~rsp_stall;
   assign ready2    = ~v2_ff | ready3;
   assign ready1    = ~v1_ff | ready2;
   assign req_stall = ~ready1;
   assign req_take  = req_valid & ready1;

   assign ctrl.s1_load = ready1;
   assign ctrl.s2_load = ready2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) v1_ff <= req_valid;
         if (ready2) v2_ff <= v1_ff;
         if (ready3) v3_ff <= v2_ff;
      end
   end

   // stage 1: absolute distances
   logic [9:0]  adx_ff, adx_in, ady_ff, ady_in;
   logic [15:0] pin1_ff;

   always_comb begin
      adx_in = abs_diff(clamp_coord(req_data.pixel_x), clamp_coord(center_x_ff));
      ady_in = abs_diff(clamp_coord(req_data.pixel_y), clamp_coord(center_y_ff));
   end

   // stage 2: squares
   logic [19:0] dx2_ff, dx2_in, dy2_ff, dy2_in, rr_ff, rr_in;
   logic [15:0] pin2_ff;

   always_comb begin
      dx2_in = 20'(adx_ff) * 20'(adx_ff);
      dy2_in = 20'(ady_ff) * 20'(ady_ff);
      rr_in  = 20'(radius_ff) * 20'(radius_ff);
   end

   // stage 3: compare and select
   logic [15:0]       blend_pixel;
   logic [20:0]       dist_sum;
   logic              in_disc;
   cmab_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      dist_sum = 21'(dx2_ff) + 21'(dy2_ff);
      in_disc  = (radius_ff != 10'd0) && (blend_alpha_ff != 8'd0) &&
                 (dist_sum <= 21'(rr_ff));
      rsp_in.pixel_out   = in_disc ? blend_pixel : pin2_ff;
      rsp_in.was_blended = in_disc;
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         adx_ff  <= adx_in;
         ady_ff  <= ady_in;
         pin1_ff <= req_data.pixel_in;
      end
      if (ready2) begin
         dx2_ff  <= dx2_in;
         dy2_ff  <= dy2_in;
         rr_ff   <= rr_in;
         pin2_ff <= pin1_ff;
      end
      if (ready3) begin
         rsp_ff <= rsp_in;
      end
   end

   cmab_blend_unit u_blend (
      .clock       (clock),
      .ctrl        (ctrl),
      .dst_pixel   (req_data.pixel_in),
      .src_pixel   (overlay_color_ff),
      .alpha       (blend_alpha_ff),
      .blend_pixel (blend_pixel)
   );

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_blend_needs_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.was_blended |-> radius_ff != 10'd0 && blend_alpha_ff != 8'd0)
      else $error("blended item with overlay disabled");

   a_stalled_item_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled output item dropped");

   a_take_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      req_take |=> v1_ff)
      else $error("accepted item not captured");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && !v1_ff && !v2_ff)
      else $error("pipeline not empty after reset");

   a_full_stall_only: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && rsp_stall)
      else $error("input stalled with room in pipeline");

endmodule
